// ----- hw/rtl/reed_solomon_encoder_top_macros.svh -----
// assertion macros for the reed-solomon encoder
// expects clk and rst_n in the scope of each use
`ifndef REED_SOLOMON_ENCODER_TOP_MACROS_SVH
`define REED_SOLOMON_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define RSE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rse assertion failed");
`define RSE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rse assertion failed");
`else
`define RSE_ASSERT_IMP(lbl, ante, cons)
`define RSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/rse_pkg.sv -----
// shared types, constants and gf(256) functions for the reed-solomon encoder
// no dependencies
package rse_pkg;

    localparam int MAX_PARITY = 32;
    localparam logic [8:0] FIELD_POLY = 9'h11D;

    typedef logic [MAX_PARITY:0][7:0] gen_coef_t;

    typedef struct packed {
        logic feed;
        logic drain;
    } rse_lfsr_ctrl_t;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [7:0] acc;
        x = a;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[k])
            begin
                acc = acc ^ x;
            end
            if (x[7])
            begin
                x = {x[6:0], 1'b0} ^ FIELD_POLY[7:0];
            end
            else
            begin
                x = {x[6:0], 1'b0};
            end
        end
        return acc;
    endfunction

    // g(x) = prod (x + alpha^i), entry 0 is the leading coefficient
    function automatic gen_coef_t gen_poly(input int n);
        gen_coef_t g;
        logic [7:0] root;
        g = '0;
        g[0] = 8'h01;
        root = 8'h01;
        for (int i = 0; i < n; i++)
        begin
            for (int j = i + 1; j >= 1; j--)
            begin
                g[j] = g[j] ^ gf_mul(g[j - 1], root);
            end
            root = gf_mul(root, 8'h02);
        end
        return g;
    endfunction

endpackage

// ----- hw/rtl/reed_solomon_encoder_top.sv -----
// systematic rs encoder over gf(256), parity_count check bytes per data_length bytes
// a byte that is taken appears on the registered output in the next cycle
// throughput: one data byte per cycle unless the output stalls, then parity_count
// parity bytes per block, set by the single output register shared by data and parity
// reset clears the parity register, counters and output valid at once
`include "reed_solomon_encoder_top_macros.svh"

module reed_solomon_encoder_top #(
    parameter int PARITY_COUNT = 32,
    parameter int DATA_LENGTH  = 223
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // out_byte
    output logic       m_axis_tuser,   // is_parity
    output logic       m_axis_tlast    // block_end
);
    import rse_pkg::*;

    localparam int CNT_W = $clog2(DATA_LENGTH + 1);
    localparam int DRN_W = $clog2(PARITY_COUNT);

    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_parity_reg, out_parity_next;
    logic             out_last_reg, out_last_next;
    logic [CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic             drain_reg, drain_next;
    logic [DRN_W-1:0] drain_cnt_reg, drain_cnt_next;

    logic           slot_free;
    logic           in_acc;
    logic           drain_load;
    logic           last_data;
    logic           last_parity;
    logic [7:0]     head;
    rse_lfsr_ctrl_t lfsr_ctrl;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = slot_free && !drain_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign drain_load    = drain_reg && slot_free;
    assign last_data     = byte_cnt_reg == CNT_W'(DATA_LENGTH - 1);
    assign last_parity   = drain_cnt_reg == DRN_W'(PARITY_COUNT - 1);

    assign lfsr_ctrl.feed  = in_acc;
    assign lfsr_ctrl.drain = drain_load;

    rse_lfsr #(
        .PARITY_COUNT(PARITY_COUNT)
    ) u_lfsr (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (lfsr_ctrl),
        .data_byte(s_axis_tdata),
        .head     (head)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_parity_next = out_parity_reg;
        out_last_next   = out_last_reg;
        byte_cnt_next   = byte_cnt_reg;
        drain_next      = drain_reg;
        drain_cnt_next  = drain_cnt_reg;
        if (in_acc)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = s_axis_tdata;
            out_parity_next = 1'b0;
            out_last_next   = 1'b0;
            if (last_data)
            begin
                byte_cnt_next = '0;
                drain_next    = 1'b1;
            end
            else
            begin
                byte_cnt_next = byte_cnt_reg + CNT_W'(1);
            end
        end
        else if (drain_load)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = head;
            out_parity_next = 1'b1;
            out_last_next   = last_parity;
            if (last_parity)
            begin
                drain_cnt_next = '0;
                drain_next     = 1'b0;
            end
            else
            begin
                drain_cnt_next = drain_cnt_reg + DRN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'h00;
            out_parity_reg <= 1'b0;
            out_last_reg   <= 1'b0;
            byte_cnt_reg   <= '0;
            drain_reg      <= 1'b0;
            drain_cnt_reg  <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_parity_reg <= out_parity_next;
            out_last_reg   <= out_last_next;
            byte_cnt_reg   <= byte_cnt_next;
            drain_reg      <= drain_next;
            drain_cnt_reg  <= drain_cnt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = out_parity_reg;
    assign m_axis_tlast  = out_last_reg;

    `RSE_ASSERT_IMP(a_no_input_in_drain, drain_reg, !s_axis_tready)
    `RSE_ASSERT_IMP(a_end_is_parity, m_axis_tvalid && m_axis_tlast, m_axis_tuser)
    `RSE_ASSERT_NXT(a_block_close_drains, in_acc && last_data, drain_reg && drain_cnt_reg == '0)
    `RSE_ASSERT_NXT(a_drain_ends, drain_load && last_parity, !drain_reg && m_axis_tlast)
    `RSE_ASSERT_IMP(a_count_idle_in_drain, drain_reg, byte_cnt_reg == '0)

endmodule

// ----- hw/rtl/rse_lfsr.sv -----
// parity remainder register with constant-coefficient feedback
// depends on rse_pkg
module rse_lfsr #(
    parameter int PARITY_COUNT = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rse_pkg::rse_lfsr_ctrl_t ctrl,
    input  logic [7:0]              data_byte,
    output logic [7:0]              head
);
    import rse_pkg::*;

    localparam gen_coef_t GEN = gen_poly(PARITY_COUNT);

    logic [PARITY_COUNT-1:0][7:0] parity_reg;
    logic [PARITY_COUNT-1:0][7:0] parity_next;
    logic [7:0]                   fb;

    assign head = parity_reg[0];

    // drain shifts with zero feedback, emptying the register as it goes
    always_comb
    begin
        fb = ctrl.feed ? (data_byte ^ parity_reg[0]) : 8'h00;
        parity_next = parity_reg;
        if (ctrl.feed || ctrl.drain)
        begin
            for (int k = 0; k < PARITY_COUNT - 1; k++)
            begin
                parity_next[k] = parity_reg[k + 1] ^ gf_mul(GEN[k + 1], fb);
            end
            parity_next[PARITY_COUNT - 1] = gf_mul(GEN[PARITY_COUNT], fb);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= '0;
        end
        else
        begin
            parity_reg <= parity_next;
        end
    end

endmodule
